/* rtl/core/shunt_sensor_frame_decoder_macros.svh */
// assertion helpers for the shunt sensor frame decoder
`ifndef SHUNT_SENSOR_FRAME_DECODER_MACROS_SVH
`define SHUNT_SENSOR_FRAME_DECODER_MACROS_SVH

// condition implies consequence in the next cycle
`define SSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// condition implies consequence in the same cycle
`define SSFD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ssfd_pkg.sv */
package ssfd_pkg;

   localparam int NUM_CHANNELS_DEF = 8;
   localparam int ACC_WIDTH_DEF    = 48;

   localparam int MODE_W  = 2;
   localparam int ID_W    = 11;
   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int CH_W    = 3;
   localparam int IDX_W   = 4;
   localparam int CNT_W   = 4;
   localparam int FLAG_W  = 4;
   localparam int TOTAL_W = 48;

   localparam logic [ID_W-1:0]   BASE_ID   = 11'h521;
   localparam logic [IDX_W-1:0]  CH_CHARGE = 4'd6;
   localparam logic [IDX_W-1:0]  CH_ENERGY = 4'd7;

   localparam logic [MODE_W-1:0] MODE_FRAME   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESYNC  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   frame_id;
      logic [BYTE_W-1:0] mux_id;
      logic [BYTE_W-1:0] frame_status;
      logic [WORD_W-1:0] payload_word;
   } req_type;

   typedef struct packed {
      logic clear;
      logic load;
   } acc_ctrl_type;

   typedef struct packed {
      logic              resync;
      logic              check;
      logic [IDX_W-1:0]  ch;
      logic [CNT_W-1:0]  cnt;
      logic [FLAG_W-1:0] flags;
   } seq_ctrl_type;

endpackage

/* rtl/core/ssfd_req_if.sv */
interface ssfd_req_if;
   logic                             valid;
   logic                             ready;
   logic [ssfd_pkg::MODE_W-1:0]      mode;
   logic [ssfd_pkg::ID_W-1:0]        frame_id;
   logic [ssfd_pkg::BYTE_W-1:0]      mux_id;
   logic [ssfd_pkg::BYTE_W-1:0]      frame_status;
   logic [ssfd_pkg::WORD_W-1:0]      payload_word;

   modport source (output valid, mode, frame_id, mux_id, frame_status, payload_word,
                   input ready);
   modport sink   (input valid, mode, frame_id, mux_id, frame_status, payload_word,
                   output ready);
endinterface

/* rtl/core/ssfd_rsp_if.sv */
interface ssfd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               accepted;
   logic [ssfd_pkg::CH_W-1:0]          channel;
   logic signed [ssfd_pkg::WORD_W-1:0] measured_value;
   logic                               counter_jump;
   logic [ssfd_pkg::FLAG_W-1:0]        fault_flags;
   logic signed [ssfd_pkg::TOTAL_W-1:0] charge_total;
   logic signed [ssfd_pkg::TOTAL_W-1:0] energy_total;
   logic [ssfd_pkg::WORD_W-1:0]        frames_seen;

   modport source (output valid, accepted, channel, measured_value, counter_jump,
                   fault_flags, charge_total, energy_total, frames_seen,
                   input ready);
   modport sink   (input valid, accepted, channel, measured_value, counter_jump,
                   fault_flags, charge_total, energy_total, frames_seen,
                   output ready);
endinterface

/* rtl/core/ssfd_seq_check.sv */
module ssfd_seq_check #(
   parameter int NUM_CHANNELS = ssfd_pkg::NUM_CHANNELS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ssfd_pkg::seq_ctrl_type        ctrl,
   output logic                          jump,
   output logic [ssfd_pkg::FLAG_W-1:0]   flags
);

   localparam int SEL_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [NUM_CHANNELS-1:0]        valid_ff, valid_in;
   logic [ssfd_pkg::CNT_W-1:0]     cnt_ff [NUM_CHANNELS];
   logic                           jump_ff, jump_in;
   logic [ssfd_pkg::FLAG_W-1:0]    flags_ff, flags_in;
   logic [SEL_W-1:0]               sel;
   logic [ssfd_pkg::CNT_W-1:0]     expected;

   assign sel      = ctrl.ch[SEL_W-1:0];
   assign expected = cnt_ff[sel] + ssfd_pkg::CNT_W'(1);

   always_comb begin
      valid_in = valid_ff;
      jump_in  = jump_ff;
      flags_in = flags_ff;
      if (ctrl.resync) begin
         valid_in = '0;
      end else if (ctrl.check) begin
         if (valid_ff[sel]) begin
            jump_in = (ctrl.cnt != expected);
         end
         valid_in[sel] = 1'b1;
         flags_in      = ctrl.flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         jump_ff  <= 1'b0;
         flags_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         jump_ff  <= jump_in;
         flags_ff <= flags_in;
      end
   end

   // counter history, qualified by the valid bits
   always_ff @(posedge clock) begin
      if (ctrl.check) begin
         cnt_ff[sel] <= ctrl.cnt;
      end
   end

   assign jump  = jump_ff;
   assign flags = flags_ff;

endmodule

/* rtl/core/ssfd_accum.sv */
module ssfd_accum #(
   parameter int ACC_WIDTH = ssfd_pkg::ACC_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ssfd_pkg::acc_ctrl_type                ctrl,
   input  logic signed [ssfd_pkg::WORD_W-1:0]    value,
   output logic signed [ssfd_pkg::TOTAL_W-1:0]   total
);

   logic signed [ssfd_pkg::WORD_W-1:0] base_ff;
   logic signed [ACC_WIDTH-1:0]        sum_ff, sum_in;
   logic                               primed_ff;
   logic signed [ssfd_pkg::WORD_W:0]   delta;
   logic signed [ACC_WIDTH:0]          wide;

   assign delta = {value[ssfd_pkg::WORD_W-1], value}
                - {base_ff[ssfd_pkg::WORD_W-1], base_ff};
   assign wide  = {sum_ff[ACC_WIDTH-1], sum_ff} + (ACC_WIDTH+1)'(delta);

   // saturate at the signed limits
   always_comb begin
      if (wide[ACC_WIDTH] != wide[ACC_WIDTH-1]) begin
         sum_in = wide[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                  : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end else begin
         sum_in = wide[ACC_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         base_ff   <= '0;
         sum_ff    <= '0;
         primed_ff <= 1'b0;
      end else if (ctrl.load) begin
         if (primed_ff) begin
            sum_ff <= sum_in;
         end
         base_ff   <= value;
         primed_ff <= 1'b1;
      end
   end

   assign total = ssfd_pkg::TOTAL_W'(sum_ff);

endmodule

/* rtl/core/shunt_sensor_frame_decoder.sv */
// Shunt sensor frame decoder.
// req_if carries one request per received CAN frame (mode 0) or a host
// command: restart (mode 1) clears both accumulators and their baselines,
// resync (mode 2) drops the rolling counter history. rsp_if returns exactly
// one result per request: decode of the frame plus a snapshot of the
// counter check latch, error flags, charge and energy totals and frame count
// as they stand after that request.
// A request passes an input register and a result register; one request can
// be taken every cycle while the receiver takes results. All decode, counter
// check and the 48-bit saturating add sit in the single stage between the two
// registers.
// When the receiver stalls, the result register holds and the input register
// fills; ready then drops until the result is taken. State only moves when
// a request passes into the result register, so the totals shown with a
// waiting result stay unchanged.
// Reset (synchronous, active high) empties both registers, clears the
// totals, latches and frame count and marks all counter history invalid.
`include "shunt_sensor_frame_decoder_macros.svh"

module shunt_sensor_frame_decoder #(
   parameter int NUM_CHANNELS = ssfd_pkg::NUM_CHANNELS_DEF,
   parameter int ACC_WIDTH    = ssfd_pkg::ACC_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   ssfd_req_if.sink   req_if,
   ssfd_rsp_if.source rsp_if
);

   logic                               s1_valid_ff, s1_valid_in;
   ssfd_pkg::req_type                  s1_ff;
   logic                               out_valid_ff, out_valid_in;
   logic                               out_accepted_ff;
   logic [ssfd_pkg::CH_W-1:0]          out_channel_ff;
   logic signed [ssfd_pkg::WORD_W-1:0] out_value_ff;
   logic [ssfd_pkg::WORD_W-1:0]        tally_ff, tally_in;

   logic                               advance;
   logic                               take;
   logic                               is_frame;
   logic [ssfd_pkg::ID_W-1:0]          diff;
   logic                               hit;
   logic [ssfd_pkg::IDX_W-1:0]         ch;
   ssfd_pkg::seq_ctrl_type             seq_ctrl;
   ssfd_pkg::acc_ctrl_type             charge_ctrl, energy_ctrl;
   logic                               jump;
   logic [ssfd_pkg::FLAG_W-1:0]        flags;
   logic signed [ssfd_pkg::TOTAL_W-1:0] charge_total, energy_total;

   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   // frame decode
   assign is_frame = (s1_ff.mode == ssfd_pkg::MODE_FRAME);
   assign diff     = s1_ff.frame_id - ssfd_pkg::BASE_ID;
   assign hit      = is_frame && (s1_ff.frame_id >= ssfd_pkg::BASE_ID)
                   && (diff < ssfd_pkg::ID_W'(NUM_CHANNELS))
                   && ({3'b000, s1_ff.mux_id} == diff);
   assign ch       = diff[ssfd_pkg::IDX_W-1:0];

   assign seq_ctrl.resync = advance && (s1_ff.mode == ssfd_pkg::MODE_RESYNC);
   assign seq_ctrl.check  = advance && hit;
   assign seq_ctrl.ch     = ch;
   assign seq_ctrl.cnt    = s1_ff.frame_status[ssfd_pkg::CNT_W-1:0];
   assign seq_ctrl.flags  = s1_ff.frame_status[ssfd_pkg::BYTE_W-1:ssfd_pkg::CNT_W];

   assign charge_ctrl.clear = advance && (s1_ff.mode == ssfd_pkg::MODE_RESTART);
   assign charge_ctrl.load  = advance && hit && (ch == ssfd_pkg::CH_CHARGE);
   assign energy_ctrl.clear = charge_ctrl.clear;
   assign energy_ctrl.load  = advance && hit && (ch == ssfd_pkg::CH_ENERGY);

   ssfd_seq_check #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_seq_check (
      .clock (clock),
      .reset (reset),
      .ctrl  (seq_ctrl),
      .jump  (jump),
      .flags (flags)
   );

   ssfd_accum #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_charge_accum (
      .clock (clock),
      .reset (reset),
      .ctrl  (charge_ctrl),
      .value (s1_ff.payload_word),
      .total (charge_total)
   );

   ssfd_accum #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_energy_accum (
      .clock (clock),
      .reset (reset),
      .ctrl  (energy_ctrl),
      .value (s1_ff.payload_word),
      .total (energy_total)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      tally_in = tally_ff;
      if (advance && is_frame) begin
         tally_in = tally_ff + ssfd_pkg::WORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tally_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         tally_ff     <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_ff.mode         <= req_if.mode;
         s1_ff.frame_id     <= req_if.frame_id;
         s1_ff.mux_id       <= req_if.mux_id;
         s1_ff.frame_status <= req_if.frame_status;
         s1_ff.payload_word <= req_if.payload_word;
      end
      if (advance) begin
         out_accepted_ff <= hit;
         out_channel_ff  <= hit ? ch[ssfd_pkg::CH_W-1:0] : '0;
         out_value_ff    <= hit ? s1_ff.payload_word : '0;
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.accepted       = out_accepted_ff;
   assign rsp_if.channel        = out_channel_ff;
   assign rsp_if.measured_value = out_value_ff;
   assign rsp_if.counter_jump   = jump;
   assign rsp_if.fault_flags    = flags;
   assign rsp_if.charge_total   = charge_total;
   assign rsp_if.energy_total   = energy_total;
   assign rsp_if.frames_seen    = tally_ff;

   `SSFD_ASSERT_NEXT(a_state_held_on_stall, rsp_if.valid && !rsp_if.ready,
      $stable(tally_ff) && $stable(charge_total) && $stable(energy_total),
      "state moved while a result was stalled")
   `SSFD_ASSERT_NEXT(a_restart_clears, advance && (s1_ff.mode == ssfd_pkg::MODE_RESTART),
      (charge_total == '0) && (energy_total == '0), "restart left a total non-zero")
   `SSFD_ASSERT_SAME(a_reject_zero, out_valid_ff && !out_accepted_ff,
      (out_channel_ff == '0) && (out_value_ff == '0), "rejected request carries data")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import ssfd_pkg::*;

   localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
   localparam int RANDOM_ITEMS  = 1650;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 80;
   localparam int SEL_W         = $clog2(NUM_CHANNELS_DEF);

   typedef struct packed {
      logic                accepted;
      logic [CH_W-1:0]     channel;
      logic [WORD_W-1:0]   measured_value;
      logic                counter_jump;
      logic [FLAG_W-1:0]   fault_flags;
      logic [TOTAL_W-1:0]  charge_total;
      logic [TOTAL_W-1:0]  energy_total;
      logic [WORD_W-1:0]   frames_seen;
   } frame_report_type;

   typedef struct {
      req_type req;
      bit      drain;
   } frame_slot_type;

   logic clock = 1'b0;
   logic reset;

   ssfd_req_if req_if();
   ssfd_rsp_if rsp_if();

   shunt_sensor_frame_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted block state
   bit   [NUM_CHANNELS_DEF-1:0] hist_valid = '0;
   logic [CNT_W-1:0]            hist_cnt [NUM_CHANNELS_DEF];
   logic                        jump_state = 1'b0;
   logic [FLAG_W-1:0]           flag_state = '0;
   logic [WORD_W-1:0]           tally = '0;
   logic signed [WORD_W-1:0]    charge_base = '0;
   logic signed [WORD_W-1:0]    energy_base = '0;
   logic signed [TOTAL_W-1:0]   charge_acc = '0;
   logic signed [TOTAL_W-1:0]   energy_acc = '0;
   bit                          charge_primed = 1'b0;
   bit                          energy_primed = 1'b0;

   frame_slot_type   pending_q[$];
   frame_report_type expected_q[$];
   int stim_total;
   int issued_count;
   int predicted_count;
   int checked_count;
   int mismatches;
   int idle_left;
   int burst_left;
   int hold_left;
   int hold_clock;
   int mon_cycle;
   int cycle_count;

   function automatic logic signed [TOTAL_W-1:0] saturating_sum(
         logic signed [TOTAL_W-1:0] acc, logic signed [WORD_W-1:0] value,
         logic signed [WORD_W-1:0] base);
      logic signed [WORD_W:0]  delta;
      logic signed [TOTAL_W:0] wide;
      delta = (WORD_W+1)'(value) - (WORD_W+1)'(base);
      wide  = (TOTAL_W+1)'(acc) + (TOTAL_W+1)'(delta);
      if (wide[TOTAL_W] != wide[TOTAL_W-1])
         return wide[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
      return wide[TOTAL_W-1:0];
   endfunction

   function automatic frame_report_type decode_frame(req_type r);
      frame_report_type  rep;
      logic [ID_W-1:0]   offset;
      logic [SEL_W-1:0]  ch;
      logic [CNT_W-1:0]  cnt;
      logic [CNT_W-1:0]  next_cnt;
      logic signed [WORD_W-1:0] value;
      rep    = '0;
      offset = r.frame_id - BASE_ID;
      case (r.mode)
         MODE_FRAME: begin
            tally = tally + 1'b1;
            if (r.frame_id >= BASE_ID && offset < NUM_CHANNELS_DEF && r.mux_id == offset) begin
               ch  = offset[SEL_W-1:0];
               cnt = r.frame_status[CNT_W-1:0];
               next_cnt = hist_cnt[ch] + 4'd1;
               if (hist_valid[ch])
                  jump_state = (cnt != next_cnt);
               hist_valid[ch] = 1'b1;
               hist_cnt[ch]   = cnt;
               flag_state     = r.frame_status[BYTE_W-1:CNT_W];
               value          = r.payload_word;
               if (ch == CH_CHARGE) begin
                  if (charge_primed)
                     charge_acc = saturating_sum(charge_acc, value, charge_base);
                  charge_base   = value;
                  charge_primed = 1'b1;
               end else if (ch == CH_ENERGY) begin
                  if (energy_primed)
                     energy_acc = saturating_sum(energy_acc, value, energy_base);
                  energy_base   = value;
                  energy_primed = 1'b1;
               end
               rep.accepted       = 1'b1;
               rep.channel        = CH_W'(ch);
               rep.measured_value = value;
            end
         end
         MODE_RESTART: begin
            charge_acc    = '0;
            energy_acc    = '0;
            charge_base   = '0;
            energy_base   = '0;
            charge_primed = 1'b0;
            energy_primed = 1'b0;
         end
         MODE_RESYNC: begin
            hist_valid = '0;
         end
         default: begin
         end
      endcase
      rep.counter_jump = jump_state;
      rep.fault_flags  = flag_state;
      rep.charge_total = charge_acc;
      rep.energy_total = energy_acc;
      rep.frames_seen  = tally;
      return rep;
   endfunction

   task automatic queue_request(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                logic [BYTE_W-1:0] mux, logic [BYTE_W-1:0] status,
                                logic [WORD_W-1:0] payload, bit drain);
      frame_slot_type s;
      s.req.mode         = mode;
      s.req.frame_id     = id;
      s.req.mux_id       = mux;
      s.req.frame_status = status;
      s.req.payload_word = payload;
      s.drain            = drain;
      pending_q.push_back(s);
   endtask

   function automatic logic [WORD_W-1:0] pick_payload();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $error("%s expected 0x%0h actual 0x%0h", name, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin : request_driver
      bit             fire;
      frame_slot_type next_slot;
      if (reset) begin
         req_if.valid <= 1'b0;
         idle_left    <= 0;
         burst_left   <= $urandom_range(1, 40);
      end else begin
         fire = req_if.valid && req_if.ready;
         if (fire) begin
            expected_q.push_back(decode_frame({req_if.mode, req_if.frame_id, req_if.mux_id,
                                               req_if.frame_status, req_if.payload_word}));
            predicted_count <= predicted_count + 1;
         end
         if (fire || !req_if.valid) begin
            if (idle_left != 0) begin
               idle_left    <= idle_left - 1;
               req_if.valid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].drain && (fire || predicted_count != checked_count))) begin
               req_if.valid <= 1'b0;
            end else begin
               next_slot = pending_q.pop_front();
               issued_count        <= issued_count + 1;
               req_if.valid        <= 1'b1;
               req_if.mode         <= next_slot.req.mode;
               req_if.frame_id     <= next_slot.req.frame_id;
               req_if.mux_id       <= next_slot.req.mux_id;
               req_if.frame_status <= next_slot.req.frame_status;
               req_if.payload_word <= next_slot.req.payload_word;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  idle_left  <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // long receiver hold-off, twice per run
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_clock <= 0;
      end else begin
         hold_clock <= hold_clock + 1;
         if (hold_left != 0)
            hold_left <= hold_left - 1;
         else if (hold_clock == 400 || hold_clock == 2400)
            hold_left <= HOLD_CYCLES;
      end
   end

   // result monitor
   always @(posedge clock) begin : result_monitor
      frame_report_type want;
      logic             take;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         mon_cycle    <= 0;
      end else begin
         mon_cycle <= mon_cycle + 1;
         if (rsp_if.valid && rsp_if.ready) begin
            if (checked_count == predicted_count) begin
               mismatches++;
               $error("result with no request outstanding");
            end else begin
               want = expected_q.pop_front();
               checked_count <= checked_count + 1;
               check_field("accepted", 64'(want.accepted), 64'(rsp_if.accepted));
               check_field("channel", 64'(want.channel), 64'(rsp_if.channel));
               check_field("measured_value", 64'(want.measured_value),
                           64'($unsigned(rsp_if.measured_value)));
               check_field("counter_jump", 64'(want.counter_jump),
                           64'(rsp_if.counter_jump));
               check_field("fault_flags", 64'(want.fault_flags), 64'(rsp_if.fault_flags));
               check_field("charge_total", 64'(want.charge_total),
                           64'($unsigned(rsp_if.charge_total)));
               check_field("energy_total", 64'(want.energy_total),
                           64'($unsigned(rsp_if.energy_total)));
               check_field("frames_seen", 64'(want.frames_seen), 64'(rsp_if.frames_seen));
            end
         end
         case (mon_cycle[8:7])
            2'd0: take = 1'b1;
            2'd1: take = ($urandom_range(0, 1) == 0);
            2'd2: take = ($urandom_range(0, 3) == 0);
            default: take = (mon_cycle[1:0] == 2'b00);
         endcase
         rsp_if.ready <= take && (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CNT_W-1:0]  gen_cnt [NUM_CHANNELS_DEF];
      logic [WORD_W-1:0] walk [NUM_CHANNELS_DEF];
      logic [SEL_W-1:0]  ch;
      logic [FLAG_W-1:0] flags;
      logic [BYTE_W-1:0] mux;
      logic [WORD_W-1:0] payload;
      int                pick;
      bit                pause;

      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.mode         = MODE_FRAME;
      req_if.frame_id     = '0;
      req_if.mux_id       = '0;
      req_if.frame_status = '0;
      req_if.payload_word = '0;
      rsp_if.ready        = 1'b0;
      issued_count        = 0;
      predicted_count     = 0;
      checked_count       = 0;
      mismatches          = 0;
      cycle_count         = 0;

      // counter history, jumps and wrap
      queue_request(MODE_FRAME, BASE_ID, 8'd0, 8'h00, 32'h0000_0000, 1'b0);
      queue_request(MODE_FRAME, BASE_ID, 8'd0, 8'hF1, 32'h7FFF_FFFF, 1'b0);
      queue_request(MODE_FRAME, BASE_ID, 8'd0, 8'h53, 32'h8000_0000, 1'b0);
      queue_request(MODE_FRAME, BASE_ID, 8'd0, 8'hAF, 32'hFFFF_FFFF, 1'b0);
      queue_request(MODE_FRAME, BASE_ID, 8'd0, 8'h00, 32'h0000_0001, 1'b0);
      for (int c = 1; c <= 5; c++)
         queue_request(MODE_FRAME, ID_W'(BASE_ID + c), 8'(c), 8'h30, $urandom, 1'b0);
      // charge and energy at the value extremes
      queue_request(MODE_FRAME, BASE_ID + 11'd6, 8'd6, 8'h00, 32'h7FFF_FFFF, 1'b0);
      queue_request(MODE_FRAME, BASE_ID + 11'd6, 8'd6, 8'h01, 32'h8000_0000, 1'b0);
      queue_request(MODE_FRAME, BASE_ID + 11'd6, 8'd6, 8'h02, 32'h7FFF_FFFF, 1'b0);
      queue_request(MODE_FRAME, BASE_ID + 11'd7, 8'd7, 8'h80, 32'h8000_0000, 1'b0);
      queue_request(MODE_FRAME, BASE_ID + 11'd7, 8'd7, 8'h81, 32'h7FFF_FFFF, 1'b0);
      // ids outside the range and a mux mismatch
      queue_request(MODE_FRAME, BASE_ID - 11'd1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0);
      queue_request(MODE_FRAME, BASE_ID + 11'd8, 8'd8, 8'h12, 32'h1234_5678, 1'b0);
      queue_request(MODE_FRAME, 11'h7FF, 8'h00, 8'h00, 32'h0, 1'b0);
      queue_request(MODE_FRAME, BASE_ID + 11'd2, 8'h05, 8'hF3, 32'h5555_AAAA, 1'b0);
      // restart after the pipeline drains, then fresh baselines
      queue_request(MODE_RESTART, 11'h7FF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      queue_request(MODE_FRAME, BASE_ID + 11'd6, 8'd6, 8'h03, 32'h0000_1234, 1'b0);
      queue_request(MODE_FRAME, BASE_ID + 11'd7, 8'd7, 8'h02, 32'hFFFF_0000, 1'b0);
      queue_request(MODE_RESYNC, BASE_ID, 8'd0, 8'h00, 32'h0, 1'b0);
      queue_request(MODE_FRAME, BASE_ID, 8'd0, 8'h07, 32'h0000_0042, 1'b0);
      queue_request(MODE_IGNORED, 11'h7FF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0);

      for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
         gen_cnt[c] = CNT_W'($urandom);
         walk[c]    = $urandom;
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick  = $urandom_range(0, 99);
         ch    = SEL_W'($urandom_range(0, NUM_CHANNELS_DEF - 1));
         pause = ($urandom_range(0, 149) == 0);
         if (pick < 70) begin
            if ($urandom_range(0, 9) == 0)
               gen_cnt[ch] = CNT_W'($urandom);
            else
               gen_cnt[ch] = gen_cnt[ch] + 4'd1;
            flags = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom);
            if ((ch == CH_CHARGE || ch == CH_ENERGY) && $urandom_range(0, 4) != 0)
               walk[ch] = walk[ch] + $urandom_range(0, 4000) - 2000;
            else
               walk[ch] = pick_payload();
            queue_request(MODE_FRAME, BASE_ID + ch, 8'(ch), {flags, gen_cnt[ch]},
                          walk[ch], pause);
         end else if (pick < 78) begin
            mux = BYTE_W'($urandom);
            if (mux == ch)
               mux = mux ^ 8'h80;
            queue_request(MODE_FRAME, BASE_ID + ch, mux, BYTE_W'($urandom), pick_payload(),
                          pause);
         end else if (pick < 86) begin
            queue_request(MODE_FRAME, ID_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                          $urandom, pause);
         end else if (pick < 90) begin
            queue_request(MODE_RESTART, ID_W'($urandom), BYTE_W'($urandom),
                          BYTE_W'($urandom), $urandom, pause);
         end else if (pick < 94) begin
            queue_request(MODE_RESYNC, ID_W'($urandom), BYTE_W'($urandom),
                          BYTE_W'($urandom), $urandom, pause);
         end else if (pick < 96) begin
            queue_request(MODE_IGNORED, ID_W'($urandom), BYTE_W'($urandom),
                          BYTE_W'($urandom), $urandom, pause);
         end else begin
            payload = pick_payload();
            queue_request(MODE_FRAME, ($urandom_range(0, 1) == 0) ? BASE_ID - 11'd1
                          : BASE_ID + 11'd8, BYTE_W'($urandom), BYTE_W'($urandom),
                          payload, pause);
         end
      end
      stim_total = pending_q.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (!(issued_count == stim_total && !req_if.valid &&
               predicted_count == checked_count));
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_q.size() != 0) begin
         mismatches++;
         $error("%0d expected results never arrived", expected_q.size());
      end
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
